[hw/rtl/tgcb_pkg.sv]
// Shared types, widths and codes for the text grid cursor buffer.
package tgcb_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 32;

   localparam int COLS_W  = 8;
   localparam int ROWS_W  = 6;
   localparam int TAB_W   = 8;
   localparam int KIND_W  = 4;
   localparam int CODE_W  = 21;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int ATYPE_W = 2;
   localparam int AVAL_W  = 48;
   localparam int AFF_W   = 6;
   localparam int ATTR_W  = ATYPE_W + AVAL_W;
   localparam int CELL_W  = 1 + CODE_W + ATTR_W;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [CODE_W-1:0]  SPACE_CODE    = 21'd32;
   localparam logic [ATYPE_W-1:0] ATYPE_INVALID = 2'd3;

   localparam logic [1:0] REG_COLS  = 2'd0;
   localparam logic [1:0] REG_ROWS  = 2'd1;
   localparam logic [1:0] REG_TAB   = 2'd2;
   localparam logic [1:0] REG_SHOWN = 2'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT_ADV  = 4'd0,
      KIND_PUT_STAY = 4'd1,
      KIND_NEWLINE  = 4'd2,
      KIND_TAB      = 4'd3,
      KIND_BACK     = 4'd4,
      KIND_SETCUR   = 4'd5,
      KIND_CLEAR    = 4'd6,
      KIND_SETATTR  = 4'd7,
      KIND_READ     = 4'd8
   } kind_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_SWEEP,
      OP_LOAD,
      OP_PUT,
      OP_ROLL,
      OP_NEWLINE,
      OP_BACK,
      OP_EXEC,
      OP_TABMOD,
      OP_CLEAR,
      OP_READ,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     sweep_last;
      logic     roll_now;
      logic     walk_last;
      logic     clear_last;
      logic     tab_mod_done;
      logic     tab_last;
      logic     tab_more;
      logic     back_origin;
   } status_type;

endpackage

[hw/rtl/tgcb_csr.sv]
// Configuration registers behind the APB-style port.
module tgcb_csr #(
   parameter int MAX_COLS = tgcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tgcb_pkg::DEF_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tgcb_pkg::ADDR_W-1:0]   paddr,
   input  logic [tgcb_pkg::DATA_W-1:0]   pwdata,
   output logic [tgcb_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [tgcb_pkg::COLS_W-1:0]   cfg_cols,
   output logic [tgcb_pkg::ROWS_W-1:0]   cfg_rows,
   output logic [tgcb_pkg::TAB_W-1:0]    cfg_tab,
   output logic                          cfg_shown,
   output logic                          cfg_home
);
   localparam int COLS_HI = (MAX_COLS > 255) ? 255 : MAX_COLS;
   localparam int ROWS_HI = (MAX_ROWS > 63) ? 63 : MAX_ROWS;
   localparam logic [tgcb_pkg::COLS_W-1:0] RST_COLS =
      tgcb_pkg::COLS_W'((80 > COLS_HI) ? COLS_HI : 80);
   localparam logic [tgcb_pkg::ROWS_W-1:0] RST_ROWS =
      tgcb_pkg::ROWS_W'((25 > ROWS_HI) ? ROWS_HI : 25);

   logic [tgcb_pkg::COLS_W-1:0] cols_ff, cols_in;
   logic [tgcb_pkg::ROWS_W-1:0] rows_ff, rows_in;
   logic [tgcb_pkg::TAB_W-1:0]  tab_ff, tab_in;
   logic                        shown_ff, shown_in;
   logic                        wr;
   logic [1:0]                  idx;
   logic [tgcb_pkg::COLS_W-1:0] wcols;
   logic [tgcb_pkg::ROWS_W-1:0] wrows;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr     = psel & penable & pwrite & (paddr[1:0] == 2'b00);
   assign wcols  = pwdata[tgcb_pkg::COLS_W-1:0];
   assign wrows  = pwdata[tgcb_pkg::ROWS_W-1:0];

   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      tab_in   = tab_ff;
      shown_in = shown_ff;
      cfg_home = 1'b0;
      if (wr) begin
         unique case (idx)
            tgcb_pkg::REG_COLS: begin
               if (wcols == '0) cols_in = tgcb_pkg::COLS_W'(1);
               else if (int'(wcols) > COLS_HI) cols_in = tgcb_pkg::COLS_W'(COLS_HI);
               else cols_in = wcols;
               cfg_home = 1'b1;
            end
            tgcb_pkg::REG_ROWS: begin
               if (wrows == '0) rows_in = tgcb_pkg::ROWS_W'(1);
               else if (int'(wrows) > ROWS_HI) rows_in = tgcb_pkg::ROWS_W'(ROWS_HI);
               else rows_in = wrows;
               cfg_home = 1'b1;
            end
            tgcb_pkg::REG_TAB:   tab_in = pwdata[tgcb_pkg::TAB_W-1:0];
            tgcb_pkg::REG_SHOWN: shown_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= RST_COLS;
         rows_ff  <= RST_ROWS;
         tab_ff   <= tgcb_pkg::TAB_W'(8);
         shown_ff <= 1'b0;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         tab_ff   <= tab_in;
         shown_ff <= shown_in;
      end
   end

   always_comb begin
      unique case (idx)
         tgcb_pkg::REG_COLS:  prdata = tgcb_pkg::DATA_W'(cols_ff);
         tgcb_pkg::REG_ROWS:  prdata = tgcb_pkg::DATA_W'(rows_ff);
         tgcb_pkg::REG_TAB:   prdata = tgcb_pkg::DATA_W'(tab_ff);
         tgcb_pkg::REG_SHOWN: prdata = tgcb_pkg::DATA_W'(shown_ff);
         default:             prdata = '0;
      endcase
   end

   assign cfg_cols  = cols_ff;
   assign cfg_rows  = rows_ff;
   assign cfg_tab   = tab_ff;
   assign cfg_shown = shown_ff;
endmodule

[hw/rtl/tgcb_datapath.sv]
// Cell store, cursor, scroll pointer, walk counters and result registers.
module tgcb_datapath #(
   parameter int MAX_COLS = tgcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tgcb_pkg::DEF_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tgcb_pkg::cmd_type             cmd,
   output tgcb_pkg::status_type          status,
   input  logic [tgcb_pkg::KIND_W-1:0]   req_kind,
   input  logic [tgcb_pkg::CODE_W-1:0]   req_char_code,
   input  logic [tgcb_pkg::COL_W-1:0]    req_col,
   input  logic [tgcb_pkg::ROW_W-1:0]    req_row,
   input  logic [tgcb_pkg::ATYPE_W-1:0]  req_attr_type,
   input  logic [tgcb_pkg::AVAL_W-1:0]   req_attr_value,
   input  logic [tgcb_pkg::COLS_W-1:0]   cfg_cols,
   input  logic [tgcb_pkg::ROWS_W-1:0]   cfg_rows,
   input  logic [tgcb_pkg::TAB_W-1:0]    cfg_tab,
   input  logic                          cfg_shown,
   input  logic                          cfg_home,
   output logic [tgcb_pkg::AFF_W-1:0]    rsp_rows_affected,
   output logic [tgcb_pkg::COL_W-1:0]    rsp_cursor_col_out,
   output logic [tgcb_pkg::ROW_W-1:0]    rsp_cursor_row_out,
   output logic [tgcb_pkg::ROW_W-1:0]    rsp_top_row_out,
   output logic [tgcb_pkg::CODE_W-1:0]   rsp_read_char,
   output logic [tgcb_pkg::ATYPE_W-1:0]  rsp_read_attr_type,
   output logic [tgcb_pkg::AVAL_W-1:0]   rsp_read_attr_value,
   output logic                          rsp_read_dirty,
   output logic                          rsp_cursor_here
);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = CW + RW;
   localparam int CIW   = tgcb_pkg::COLS_W + 1;
   localparam int RIW   = tgcb_pkg::ROWS_W + 1;
   localparam int DEPTH = 2 ** AW;

   logic [tgcb_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tgcb_pkg::CELL_W-1:0] mem_q_ff;

   logic [CW-1:0] col_ff, col_in, walk_c_ff, walk_c_in;
   logic [RW-1:0] row_ff, row_in, top_ff, top_in, walk_r_ff, walk_r_in;
   logic [tgcb_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [tgcb_pkg::AFF_W-1:0] acc_ff, acc_in;
   logic [tgcb_pkg::TAB_W-1:0] rem_ff, rem_in, cnt_ff, cnt_in, tw;

   tgcb_pkg::kind_type kind_ff;
   logic [tgcb_pkg::CODE_W-1:0]  code_ff;
   logic [tgcb_pkg::COL_W-1:0]   icol_ff;
   logic [tgcb_pkg::ROW_W-1:0]   irow_ff;
   logic [tgcb_pkg::ATYPE_W-1:0] atype_ff;
   logic [tgcb_pkg::AVAL_W-1:0]  aval_ff;

   logic [CIW-1:0] col_inc;
   logic [RIW-1:0] row_inc, top_inc, prow_sum, prow_full, irow_sum, irow_full;
   logic [RIW-1:0] acc_sum, row_step;
   logic [RW-1:0]  prow, iprow;
   logic wrap, row_full, top_wrap, advance, in_grid, walk_last;
   logic [tgcb_pkg::CODE_W-1:0] put_code;
   logic [tgcb_pkg::AFF_W-1:0]  acc_step;

   logic                        we;
   logic [AW-1:0]               waddr;
   logic [tgcb_pkg::CELL_W-1:0] wdata;

   assign tw       = (cfg_tab == '0) ? tgcb_pkg::TAB_W'(1) : cfg_tab;
   assign col_inc  = CIW'(col_ff) + CIW'(1);
   assign wrap     = col_inc >= CIW'(cfg_cols);
   assign row_inc  = RIW'(row_ff) + RIW'(1);
   assign row_full = row_inc >= RIW'(cfg_rows);
   assign top_inc  = RIW'(top_ff) + RIW'(1);
   assign top_wrap = top_inc >= RIW'(cfg_rows);

   // ring position of the cursor row and of the addressed row
   assign prow_sum  = RIW'(top_ff) + RIW'(row_ff);
   assign prow_full = (prow_sum >= RIW'(cfg_rows)) ? prow_sum - RIW'(cfg_rows) : prow_sum;
   assign prow      = prow_full[RW-1:0];
   assign irow_sum  = RIW'(top_ff) + RIW'(irow_ff);
   assign irow_full = (irow_sum >= RIW'(cfg_rows)) ? irow_sum - RIW'(cfg_rows) : irow_sum;
   assign iprow     = irow_full[RW-1:0];

   assign in_grid = (tgcb_pkg::COLS_W'(icol_ff) < cfg_cols) &&
                    (tgcb_pkg::ROWS_W'(irow_ff) < cfg_rows);
   assign advance  = (kind_ff == tgcb_pkg::KIND_PUT_ADV) || (kind_ff == tgcb_pkg::KIND_TAB);
   assign put_code = ((kind_ff == tgcb_pkg::KIND_PUT_ADV) ||
                      (kind_ff == tgcb_pkg::KIND_PUT_STAY)) ? code_ff : tgcb_pkg::SPACE_CODE;
   assign walk_last = tgcb_pkg::COLS_W'(walk_c_ff) == (cfg_cols - tgcb_pkg::COLS_W'(1));

   // one extra row, or the whole screen on a scroll, saturated to the row count
   assign acc_step = row_full ? cfg_rows - tgcb_pkg::ROWS_W'(1) : tgcb_pkg::AFF_W'(1);
   assign acc_sum  = RIW'(acc_ff) + RIW'(acc_step);
   assign row_step = (acc_sum > RIW'(cfg_rows)) ? RIW'(cfg_rows) : acc_sum;

   always_comb begin
      status.kind         = kind_ff;
      status.sweep_last   = &sweep_ff;
      status.roll_now     = (kind_ff == tgcb_pkg::KIND_NEWLINE) ? row_full
                                                                : (advance & wrap & row_full);
      status.walk_last    = walk_last;
      status.clear_last   = walk_last &&
                            (tgcb_pkg::ROWS_W'(walk_r_ff) == cfg_rows - tgcb_pkg::ROWS_W'(1));
      status.tab_mod_done = rem_ff < tw;
      status.tab_last     = cnt_ff == tgcb_pkg::TAB_W'(1);
      status.tab_more     = cnt_ff != '0;
      status.back_origin  = (col_ff == '0) && (row_ff == '0);
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      top_in    = top_ff;
      attr_in   = attr_ff;
      sweep_in  = sweep_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      walk_c_in = walk_c_ff;
      walk_r_in = walk_r_ff;
      we        = 1'b0;
      waddr     = {prow, col_ff};
      wdata     = {1'b1, tgcb_pkg::CODE_W'(0), attr_ff};
      unique case (cmd.op)
         tgcb_pkg::OP_SWEEP: begin
            we       = 1'b1;
            waddr    = sweep_ff;
            wdata    = {1'b1, tgcb_pkg::CODE_W'(0), tgcb_pkg::ATTR_W'(0)};
            sweep_in = sweep_ff + AW'(1);
         end
         tgcb_pkg::OP_LOAD: begin
            walk_c_in = '0;
            walk_r_in = '0;
            rem_in    = tgcb_pkg::TAB_W'(col_ff);
            unique case (tgcb_pkg::kind_type'(req_kind))
               tgcb_pkg::KIND_PUT_ADV, tgcb_pkg::KIND_PUT_STAY,
               tgcb_pkg::KIND_NEWLINE, tgcb_pkg::KIND_TAB: acc_in = tgcb_pkg::AFF_W'(1);
               tgcb_pkg::KIND_BACK: begin
                  if (col_ff == '0 && row_ff == '0) acc_in = '0;
                  else if (col_ff == '0) acc_in = tgcb_pkg::AFF_W'(2);
                  else acc_in = tgcb_pkg::AFF_W'(1);
               end
               default: acc_in = '0;
            endcase
         end
         tgcb_pkg::OP_PUT: begin
            we        = 1'b1;
            wdata     = {1'b1, put_code, attr_ff};
            walk_c_in = '0;
            cnt_in    = cnt_ff - tgcb_pkg::TAB_W'(1);
            if (advance) begin
               if (wrap) begin
                  col_in = '0;
                  acc_in = row_step[tgcb_pkg::AFF_W-1:0];
                  if (row_full) top_in = top_wrap ? '0 : top_inc[RW-1:0];
                  else row_in = row_inc[RW-1:0];
               end else begin
                  col_in = col_inc[CW-1:0];
               end
            end
         end
         tgcb_pkg::OP_NEWLINE: begin
            col_in    = '0;
            walk_c_in = '0;
            acc_in    = row_step[tgcb_pkg::AFF_W-1:0];
            if (row_full) top_in = top_wrap ? '0 : top_inc[RW-1:0];
            else row_in = row_inc[RW-1:0];
         end
         tgcb_pkg::OP_ROLL: begin
            we        = 1'b1;
            waddr     = {prow, walk_c_ff};
            walk_c_in = walk_c_ff + CW'(1);
         end
         tgcb_pkg::OP_CLEAR: begin
            we    = 1'b1;
            waddr = {walk_r_ff, walk_c_ff};
            if (walk_last) begin
               walk_c_in = '0;
               walk_r_in = walk_r_ff + RW'(1);
            end else begin
               walk_c_in = walk_c_ff + CW'(1);
            end
            if (status.clear_last) begin
               col_in = '0;
               row_in = '0;
               acc_in = cfg_rows;
            end
         end
         tgcb_pkg::OP_BACK: begin
            if (col_ff != '0) begin
               col_in = col_ff - CW'(1);
            end else if (row_ff != '0) begin
               col_in = CW'(cfg_cols - tgcb_pkg::COLS_W'(1));
               row_in = row_ff - RW'(1);
            end
         end
         tgcb_pkg::OP_TABMOD: begin
            if (rem_ff >= tw) rem_in = rem_ff - tw;
            else cnt_in = tw - rem_ff;
         end
         tgcb_pkg::OP_EXEC: begin
            if (kind_ff == tgcb_pkg::KIND_SETCUR && in_grid) begin
               col_in = CW'(icol_ff);
               row_in = RW'(irow_ff);
            end
            if (kind_ff == tgcb_pkg::KIND_SETATTR && atype_ff != tgcb_pkg::ATYPE_INVALID)
               attr_in = {atype_ff, aval_ff};
         end
         tgcb_pkg::OP_IDLE, tgcb_pkg::OP_READ, tgcb_pkg::OP_FINISH: ;
         default: ;
      endcase
      if (cfg_home) begin
         col_in = '0;
         row_in = '0;
         top_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         top_ff   <= '0;
         attr_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         top_ff   <= top_in;
         attr_ff  <= attr_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      walk_c_ff <= walk_c_in;
      walk_r_ff <= walk_r_in;
      if (cmd.op == tgcb_pkg::OP_LOAD) begin
         kind_ff  <= tgcb_pkg::kind_type'(req_kind);
         code_ff  <= req_char_code;
         icol_ff  <= req_col;
         irow_ff  <= req_row;
         atype_ff <= req_attr_type;
         aval_ff  <= req_attr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.op == tgcb_pkg::OP_READ) mem_q_ff <= mem[{iprow, CW'(icol_ff)}];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tgcb_pkg::OP_FINISH) begin
         rsp_rows_affected  <= acc_ff;
         rsp_cursor_col_out <= tgcb_pkg::COL_W'(col_ff);
         rsp_cursor_row_out <= tgcb_pkg::ROW_W'(row_ff);
         rsp_top_row_out    <= tgcb_pkg::ROW_W'(top_ff);
         if (kind_ff == tgcb_pkg::KIND_READ && in_grid) begin
            rsp_read_dirty      <= mem_q_ff[tgcb_pkg::CELL_W-1];
            rsp_read_char       <= mem_q_ff[tgcb_pkg::CELL_W-2 -: tgcb_pkg::CODE_W];
            rsp_read_attr_type  <= mem_q_ff[tgcb_pkg::ATTR_W-1 -: tgcb_pkg::ATYPE_W];
            rsp_read_attr_value <= mem_q_ff[tgcb_pkg::AVAL_W-1:0];
            rsp_cursor_here     <= cfg_shown && (col_ff == CW'(icol_ff)) &&
                                   (row_ff == RW'(irow_ff));
         end else begin
            rsp_read_dirty      <= 1'b0;
            rsp_read_char       <= '0;
            rsp_read_attr_type  <= '0;
            rsp_read_attr_value <= '0;
            rsp_cursor_here     <= 1'b0;
         end
      end
   end
endmodule

[hw/rtl/tgcb_ctrl.sv]
// Command sequencer: steps the datapath through each command.
module tgcb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  tgcb_pkg::status_type  status,
   output tgcb_pkg::cmd_type     cmd
);
   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_DISPATCH, S_TABMOD, S_TABPUT, S_BSPUT,
      S_ROLL, S_CLEAR, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = tgcb_pkg::OP_IDLE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.op = tgcb_pkg::OP_SWEEP;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = tgcb_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.kind)
               tgcb_pkg::KIND_PUT_ADV, tgcb_pkg::KIND_PUT_STAY: begin
                  cmd.op   = tgcb_pkg::OP_PUT;
                  state_in = status.roll_now ? S_ROLL : S_FINISH;
               end
               tgcb_pkg::KIND_NEWLINE: begin
                  cmd.op   = tgcb_pkg::OP_NEWLINE;
                  state_in = status.roll_now ? S_ROLL : S_FINISH;
               end
               tgcb_pkg::KIND_TAB: begin
                  cmd.op   = tgcb_pkg::OP_TABMOD;
                  state_in = status.tab_mod_done ? S_TABPUT : S_TABMOD;
               end
               tgcb_pkg::KIND_BACK: begin
                  cmd.op   = tgcb_pkg::OP_BACK;
                  state_in = status.back_origin ? S_FINISH : S_BSPUT;
               end
               tgcb_pkg::KIND_CLEAR: begin
                  cmd.op   = tgcb_pkg::OP_CLEAR;
                  state_in = status.clear_last ? S_FINISH : S_CLEAR;
               end
               tgcb_pkg::KIND_READ: begin
                  cmd.op   = tgcb_pkg::OP_READ;
                  state_in = S_FINISH;
               end
               default: begin
                  cmd.op   = tgcb_pkg::OP_EXEC;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_TABMOD: begin
            cmd.op = tgcb_pkg::OP_TABMOD;
            if (status.tab_mod_done) state_in = S_TABPUT;
         end
         S_TABPUT: begin
            cmd.op = tgcb_pkg::OP_PUT;
            if (status.roll_now) state_in = S_ROLL;
            else if (status.tab_last) state_in = S_FINISH;
         end
         S_BSPUT: begin
            cmd.op   = tgcb_pkg::OP_PUT;
            state_in = S_FINISH;
         end
         S_ROLL: begin
            cmd.op = tgcb_pkg::OP_ROLL;
            if (status.walk_last)
               state_in = (status.kind == tgcb_pkg::KIND_TAB && status.tab_more) ?
                          S_TABPUT : S_FINISH;
         end
         S_CLEAR: begin
            cmd.op = tgcb_pkg::OP_CLEAR;
            if (status.clear_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.op       = tgcb_pkg::OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

[hw/rtl/text_grid_cursor_buffer_unit.sv]
// Top level of the text grid cursor buffer: registers, sequencer and cell store.
//
// Character-cell text buffer of up to MAX_ROWS x MAX_COLS cells, each holding a
// code point, a dirty mark and an attribute, with the cursor kept in a ring of
// rows that scrolls by moving the top-row pointer. One command per req transfer,
// one result per command on rsp. After reset the store is swept clean, one cell
// a cycle, over all 2**clog2(MAX_ROWS) * 2**clog2(MAX_COLS) cells (4096 at the
// defaults); req is stalled meanwhile but register writes are taken. Each command
// steps through load, execute and result load, and a backspace that moves also
// writes a space to the store. A scroll adds a walk that clears the new bottom
// row; a clear walks every active cell; a tab first subtracts tab_width from the
// column until under it to find the distance to the next stop, then writes one
// space per position, plus any scroll walks. The next command is taken the
// cycle after the result is loaded. A finished result sits in the output register
// until taken.
module text_grid_cursor_buffer_unit #(
   parameter int MAX_COLS = tgcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tgcb_pkg::DEF_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tgcb_pkg::KIND_W-1:0]   req_kind,
   input  logic [tgcb_pkg::CODE_W-1:0]   req_char_code,
   input  logic [tgcb_pkg::COL_W-1:0]    req_col,
   input  logic [tgcb_pkg::ROW_W-1:0]    req_row,
   input  logic [tgcb_pkg::ATYPE_W-1:0]  req_attr_type,
   input  logic [tgcb_pkg::AVAL_W-1:0]   req_attr_value,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tgcb_pkg::AFF_W-1:0]    rsp_rows_affected,
   output logic [tgcb_pkg::COL_W-1:0]    rsp_cursor_col_out,
   output logic [tgcb_pkg::ROW_W-1:0]    rsp_cursor_row_out,
   output logic [tgcb_pkg::ROW_W-1:0]    rsp_top_row_out,
   output logic [tgcb_pkg::CODE_W-1:0]   rsp_read_char,
   output logic [tgcb_pkg::ATYPE_W-1:0]  rsp_read_attr_type,
   output logic [tgcb_pkg::AVAL_W-1:0]   rsp_read_attr_value,
   output logic                          rsp_read_dirty,
   output logic                          rsp_cursor_here,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tgcb_pkg::ADDR_W-1:0]   paddr,
   input  logic [tgcb_pkg::DATA_W-1:0]   pwdata,
   output logic [tgcb_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   logic [tgcb_pkg::COLS_W-1:0] cfg_cols;
   logic [tgcb_pkg::ROWS_W-1:0] cfg_rows;
   logic [tgcb_pkg::TAB_W-1:0]  cfg_tab;
   logic                        cfg_shown;
   logic                        cfg_home;
   tgcb_pkg::cmd_type           cmd;
   tgcb_pkg::status_type        status;

   // registers; a grid size write homes the cursor and the top row
   tgcb_csr #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_csr (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .cfg_cols(cfg_cols), .cfg_rows(cfg_rows), .cfg_tab(cfg_tab),
      .cfg_shown(cfg_shown), .cfg_home(cfg_home)
   );

   // sequencer: one command in flight, result held until its transfer
   tgcb_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   // cell store, cursor state and result registers
   tgcb_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_kind(req_kind), .req_char_code(req_char_code), .req_col(req_col),
      .req_row(req_row), .req_attr_type(req_attr_type),
      .req_attr_value(req_attr_value),
      .cfg_cols(cfg_cols), .cfg_rows(cfg_rows), .cfg_tab(cfg_tab),
      .cfg_shown(cfg_shown), .cfg_home(cfg_home),
      .rsp_rows_affected(rsp_rows_affected),
      .rsp_cursor_col_out(rsp_cursor_col_out),
      .rsp_cursor_row_out(rsp_cursor_row_out),
      .rsp_top_row_out(rsp_top_row_out),
      .rsp_read_char(rsp_read_char),
      .rsp_read_attr_type(rsp_read_attr_type),
      .rsp_read_attr_value(rsp_read_attr_value),
      .rsp_read_dirty(rsp_read_dirty),
      .rsp_cursor_here(rsp_cursor_here)
   );
endmodule
